### design/gclu_pkg.sv
// ----------------------------------------------------------------------------
// gclu_pkg
// shared widths, constants and handshake structs of the gcd / lcm set unit
// ----------------------------------------------------------------------------
package gclu_pkg;

	localparam int VALUE_BITS = 31;
	localparam int IN_BITS    = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS = 2 * VALUE_BITS + 1;
	localparam int OUT_BITS   = ((OUT_FIELDS + 7) / 8) * 8;
	localparam int PROD_BITS  = 2 * VALUE_BITS;
	localparam int CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;
	localparam logic [CNT_BITS-1:0]   DIV_LAST   = CNT_BITS'(VALUE_BITS - 1);

	// request into the shared divider
	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [VALUE_BITS-1:0] divisor;
	} div_req_t;

	// status and result of the shared divider
	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [VALUE_BITS-1:0] remainder;
	} div_rsp_t;

endpackage

### design/gclu_div.sv
// ----------------------------------------------------------------------------
// gclu_div
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module gclu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  gclu_pkg::div_req_t req,
	output gclu_pkg::div_rsp_t rsp
);
	import gclu_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [VALUE_BITS:0]   rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] dvs_q;

	logic [VALUE_BITS:0]   rem_sh;
	logic [VALUE_BITS+1:0] diff;
	logic                  fits;

	assign rem_sh = {rem_q[VALUE_BITS-1:0], quo_q[VALUE_BITS-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits   = ~diff[VALUE_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			// done pulses for one cycle after the last quotient bit
			done_q <= busy_q && (cnt_q == '0);
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_LAST;
				rem_q  <= '0;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				// shift in next dividend bit, subtract when it fits
				rem_q <= fits ? diff[VALUE_BITS:0] : rem_sh;
				quo_q <= {quo_q[VALUE_BITS-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q[VALUE_BITS-1:0];

endmodule

### design/gcd_lcm_set_reduction_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_set_reduction_unit
// running gcd and lcm over a set of unsigned values, one result per set
// ----------------------------------------------------------------------------
// usage:
//  - input stream: one set element per transfer; tdata holds the value,
//    tuser marks the first element of a set, tlast marks the last one
//  - output stream: one transfer per set, produced by the element that
//    carries tlast: gcd, lcm (saturated) and an lcm overflow flag
//  - each element is handled alone; tready is low while it is worked on
//  - a first element only starts a new set; any other element runs euclid's
//    loop on the running gcd, then (unless lcm or value is zero or lcm is
//    saturated) euclid's loop on the running lcm, one divide and one multiply
//  - every remainder step uses the shared 1-bit-per-cycle divider
//  - results go to an output register; the next element is accepted while
//    a result waits, and a new result waits in the sequencer until the
//    register is free when the receiver stalls
//  - reset clears running gcd, lcm and overflow to zero; elements without
//    a first mark join the current set
// ----------------------------------------------------------------------------
module gcd_lcm_set_reduction_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [gclu_pkg::IN_BITS-1:0] s_axis_tdata,  // value, zero pad
	input  logic                         s_axis_tuser,  // first_item
	input  logic                         s_axis_tlast,  // last_item
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [gclu_pkg::OUT_BITS-1:0] m_axis_tdata  // gcd_result,
	                                                    // lcm_result,
	                                                    // lcm_overflow, zero pad
);
	import gclu_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_EUC      = 7'b0000010,
		ST_EUC_WAIT = 7'b0000100,
		ST_QUO      = 7'b0001000,
		ST_MUL      = 7'b0010000,
		ST_CHK      = 7'b0100000,
		ST_FIN      = 7'b1000000
	} state_t;

	state_t state_q;

	// architectural set state
	logic [VALUE_BITS-1:0] gcd_q;
	logic [VALUE_BITS-1:0] lcm_q;
	logic                  ovf_q;

	// per-element working registers
	logic [VALUE_BITS-1:0] val_q;
	logic                  last_q;
	logic [VALUE_BITS-1:0] x_q;
	logic [VALUE_BITS-1:0] y_q;
	logic                  phase_q;   // 0: gcd loop, 1: lcm loop
	logic [VALUE_BITS-1:0] quo_q;
	logic [PROD_BITS-1:0]  prod_q;

	// output register
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_gcd_q;
	logic [VALUE_BITS-1:0] out_lcm_q;
	logic                  out_ovf_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic in_xfer;
	logic out_free;
	logic out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	// finished last element moves its result into the output register
	assign out_load      = (state_q == ST_FIN) && last_q && out_free;

	// divider request: a remainder step, or lcm / gcd at the end of the lcm loop
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = x_q;
		div_req.divisor  = y_q;
		if (state_q == ST_EUC) begin
			if (y_q != '0) begin
				div_req.start = 1'b1;
			end else if (phase_q) begin
				div_req.start    = 1'b1;
				div_req.dividend = lcm_q;
				div_req.divisor  = x_q;
			end
		end
	end

	gclu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gcd_q       <= '0;
			lcm_q       <= '0;
			ovf_q       <= 1'b0;
			val_q       <= '0;
			last_q      <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			phase_q     <= 1'b0;
			quo_q       <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			out_gcd_q   <= '0;
			out_lcm_q   <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						val_q   <= s_axis_tdata[VALUE_BITS-1:0];
						last_q  <= s_axis_tlast;
						x_q     <= gcd_q;
						y_q     <= s_axis_tdata[VALUE_BITS-1:0];
						phase_q <= 1'b0;
						if (s_axis_tuser) begin
							// new set starts from this element
							gcd_q   <= s_axis_tdata[VALUE_BITS-1:0];
							lcm_q   <= s_axis_tdata[VALUE_BITS-1:0];
							ovf_q   <= 1'b0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_EUC;
						end
					end
				end
				ST_EUC: begin
					if (y_q != '0) begin
						state_q <= ST_EUC_WAIT;
					end else if (phase_q) begin
						// x_q holds gcd(lcm, value); divider now forms lcm / gcd
						state_q <= ST_QUO;
					end else begin
						gcd_q <= x_q;
						if (ovf_q) begin
							state_q <= ST_FIN;
						end else if (lcm_q == '0 || val_q == '0) begin
							lcm_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							x_q     <= lcm_q;
							y_q     <= val_q;
							phase_q <= 1'b1;
						end
					end
				end
				ST_EUC_WAIT: begin
					if (div_rsp.done) begin
						x_q     <= y_q;
						y_q     <= div_rsp.remainder;
						state_q <= ST_EUC;
					end
				end
				ST_QUO: begin
					if (div_rsp.done) begin
						quo_q   <= div_rsp.quotient;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_BITS'(quo_q) * PROD_BITS'(val_q);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// saturate when the product leaves the value range
					if (prod_q[PROD_BITS-1:VALUE_BITS] != '0) begin
						lcm_q <= VALUE_MASK;
						ovf_q <= 1'b1;
					end else begin
						lcm_q <= prod_q[VALUE_BITS-1:0];
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_gcd_q   <= gcd_q;
						out_lcm_q   <= lcm_q;
						out_ovf_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_BITS - OUT_FIELDS)'(0), out_ovf_q, out_lcm_q, out_gcd_q};

	// a saturated lcm always reads as the all-ones value
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (lcm_q == VALUE_MASK))
		else $error("overflow flag set without saturated lcm");

	// the divider is only started while idle
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// divider results only arrive while the sequencer waits for them
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_EUC_WAIT || state_q == ST_QUO))
		else $error("divider result with no waiting step");

	// lcm / gcd is never zero since lcm holds a multiple of gcd
	a_quo_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (quo_q != '0))
		else $error("zero quotient in lcm step");

	// a stalled result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_lcm_q)))
		else $error("pending result overwritten");

endmodule
